[hw/rtl/dor_pkg.sv]
package dor_pkg;

    localparam int YEAR_W   = 12;
    localparam int RULE_W   = 15;
    localparam int OFFS_W   = 4;
    localparam int SEC_W    = 25;
    localparam int DAYN_W   = 9;
    localparam int WSUM_W   = 13;

    localparam int SEC_PER_DAY  = 86400;
    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;

    localparam logic [1:0] CFG_START  = 2'd0;
    localparam logic [1:0] CFG_END    = 2'd1;
    localparam logic [1:0] CFG_OFFSET = 2'd2;

    localparam logic [RULE_W-1:0] START_RULE_RST = 15'd6466;
    localparam logic [RULE_W-1:0] END_RULE_RST   = 15'd22818;
    localparam logic [OFFS_W-1:0] OFFSET_RST     = 4'd1;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // per-stage load strobes of the pipeline
    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
        logic st4;
        logic st5;
        logic st6;
        logic st7;
    } adv_t;

    function automatic logic [3:0] clamp_month(input logic [3:0] m);
        logic [3:0] r;
        r = m;
        if (m == 4'd0) begin
            r = 4'd1;
        end else if (m > MONTH_DEC) begin
            r = MONTH_DEC;
        end
        return r;
    endfunction

    // floor(y / 100) through a reciprocal, exact for y below 43690
    function automatic logic [6:0] div100(input logic [12:0] y);
        logic [25:0] p;
        p = {13'b0, y} * 26'd5243;
        return p[25:19];
    endfunction

    // x mod 7 through a reciprocal, exact for x below 13107
    function automatic logic [2:0] mod7(input logic [12:0] x);
        logic [26:0] p;
        logic [12:0] q7;
        logic [12:0] r;
        p  = {14'b0, x} * 27'd9363;
        q7 = {2'b0, p[26:16]} * 13'd7;
        r  = x - q7;
        return r[2:0];
    endfunction

    function automatic logic [4:0] days_in_month(input logic [3:0] m);
        logic [4:0] d;
        unique case (m)
            4'd2:                      d = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // month part of the weekday sum for day one, with the two constant ones folded in;
    // january and february count as months 13 and 14 of the year before
    function automatic logic [5:0] month_term(input logic [3:0] m);
        logic [5:0] t;
        unique case (m)
            4'd2:    t = 6'd39;
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            default: t = 6'd36;
        endcase
        return t;
    endfunction

endpackage

[hw/rtl/dst_offset_from_rules.sv]
// an accepted input beat passes registered stages 1 to 7 in order to its result beat
// throughput: one beat per cycle; depth set by the seven-stage calendar pipeline
//   (year terms, weekday mod 7, nth-weekday day pull-back, seconds, window compare)
// each stage holds a beat until the next frees up, so bubbles fill under back-pressure
// reset (aresetn low, synchronous) empties the pipeline and loads the default
//   rules: march 2nd sunday 02:00 to november 1st sunday 02:00, offset one hour
module dst_offset_from_rules (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [dor_pkg::RULE_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dor_pkg::YEAR_W-1:0]    s_cal_year,
    input  logic [3:0]                    s_cal_month,
    input  logic [4:0]                    s_cal_day,
    input  logic [4:0]                    s_cal_hour,
    input  logic [5:0]                    s_cal_minute,
    input  logic [5:0]                    s_cal_second,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dor_pkg::OFFS_W-1:0]    m_dst_hours,
    output logic                          m_in_dst
);

    localparam int NSTG = 7;

    // configuration registers
    logic [dor_pkg::RULE_W-1:0] start_rule_reg, end_rule_reg;
    logic [dor_pkg::OFFS_W-1:0] offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_rule_reg <= dor_pkg::START_RULE_RST;
            end_rule_reg   <= dor_pkg::END_RULE_RST;
            offset_reg     <= dor_pkg::OFFSET_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                dor_pkg::CFG_START:  start_rule_reg <= cfg_wdata;
                dor_pkg::CFG_END:    end_rule_reg   <= cfg_wdata;
                dor_pkg::CFG_OFFSET: offset_reg     <= cfg_wdata[dor_pkg::OFFS_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control: a stage loads when it is empty or the one after it moves
    logic [NSTG:1]   valid_reg, valid_next;
    logic [NSTG+1:1] rdy;
    dor_pkg::adv_t   adv;

    always_comb begin
        rdy[NSTG+1] = m_ready;
        for (int k = NSTG; k >= 1; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        valid_next = valid_reg;
        if (rdy[1]) begin
            valid_next[1] = s_valid;
        end
        for (int k = 2; k <= NSTG; k++) begin
            if (rdy[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign adv = '{st1: rdy[1], st2: rdy[2], st3: rdy[3], st4: rdy[4],
                   st5: rdy[5], st6: rdy[6], st7: rdy[7]};

    assign s_ready = rdy[1];

    logic [dor_pkg::WSUM_W-1:0] wsum_cur, wsum_prev;
    logic                       leap;
    logic [dor_pkg::SEC_W-1:0]  now_sec, start_sec, end_sec;

    dor_time_path u_time (
        .aclk       (aclk),
        .adv        (adv),
        .cal_year   (s_cal_year),
        .cal_month  (s_cal_month),
        .cal_day    (s_cal_day),
        .cal_hour   (s_cal_hour),
        .cal_minute (s_cal_minute),
        .cal_second (s_cal_second),
        .wsum_cur   (wsum_cur),
        .wsum_prev  (wsum_prev),
        .leap       (leap),
        .now_sec    (now_sec)
    );

    dor_rule_path u_start (
        .aclk      (aclk),
        .adv       (adv),
        .rule      (start_rule_reg),
        .wsum_cur  (wsum_cur),
        .wsum_prev (wsum_prev),
        .leap      (leap),
        .rule_sec  (start_sec)
    );

    dor_rule_path u_end (
        .aclk      (aclk),
        .adv       (adv),
        .rule      (end_rule_reg),
        .wsum_cur  (wsum_cur),
        .wsum_prev (wsum_prev),
        .leap      (leap),
        .rule_sec  (end_sec)
    );

    // stage 7: window compare, wrapped when start is not before end
    logic                       in_dst_next, in_dst_reg;
    logic [dor_pkg::OFFS_W-1:0] dst_hours_next, dst_hours_reg;

    always_comb begin
        if (start_sec < end_sec) begin
            in_dst_next = (now_sec >= start_sec) && (now_sec < end_sec);
        end else begin
            in_dst_next = (now_sec >= start_sec) || (now_sec < end_sec);
        end
        dst_hours_next = in_dst_next ? offset_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (adv.st7) begin
            in_dst_reg    <= in_dst_next;
            dst_hours_reg <= dst_hours_next;
        end
    end

    assign m_valid     = valid_reg[NSTG];
    assign m_in_dst    = in_dst_reg;
    assign m_dst_hours = dst_hours_reg;

endmodule

[hw/rtl/dor_time_path.sv]
module dor_time_path (
    input  logic                          aclk,
    input  dor_pkg::adv_t                 adv,
    input  logic [dor_pkg::YEAR_W-1:0]    cal_year,
    input  logic [3:0]                    cal_month,
    input  logic [4:0]                    cal_day,
    input  logic [4:0]                    cal_hour,
    input  logic [5:0]                    cal_minute,
    input  logic [5:0]                    cal_second,
    output logic [dor_pkg::WSUM_W-1:0]    wsum_cur,
    output logic [dor_pkg::WSUM_W-1:0]    wsum_prev,
    output logic                          leap,
    output logic [dor_pkg::SEC_W-1:0]     now_sec
);

    // stage 1: year offsets by 400 and 399 and their centuries
    logic [12:0] y0_reg, y0_next, y1_reg, y1_next;
    logic [6:0]  q0_reg, q0_next, q1_reg, q1_next;
    logic [3:0]  mo1_reg, mo1_next;
    logic [4:0]  da1_reg, hr1_reg;
    logic [5:0]  mi1_reg, se1_reg;

    assign y0_next  = {1'b0, cal_year} + 13'd400;
    assign y1_next  = {1'b0, cal_year} + 13'd399;
    assign q0_next  = dor_pkg::div100(y0_next);
    assign q1_next  = dor_pkg::div100(y1_next);
    assign mo1_next = dor_pkg::clamp_month(cal_month);

    always_ff @(posedge aclk) begin
        if (adv.st1) begin
            y0_reg  <= y0_next;
            y1_reg  <= y1_next;
            q0_reg  <= q0_next;
            q1_reg  <= q1_next;
            mo1_reg <= mo1_next;
            da1_reg <= cal_day;
            hr1_reg <= cal_hour;
            mi1_reg <= cal_minute;
            se1_reg <= cal_second;
        end
    end

    // stage 2: leap flag, weekday year terms, day number of the timestamp
    logic [12:0] hund;
    logic [12:0] r100;
    logic        leap_next, leap_reg;
    logic [dor_pkg::WSUM_W-1:0] w0_next, w0_reg, w1_next, w1_reg;
    logic [dor_pkg::DAYN_W-1:0] dn2_next, dn2_reg;
    logic [4:0]  hr2_reg;
    logic [5:0]  mi2_reg, se2_reg;

    assign hund      = {6'b0, q0_reg} * 13'd100;
    assign r100      = y0_reg - hund;
    assign leap_next = ((y0_reg[1:0] == 2'b00) && (r100 != 13'd0))
                     || ((r100 == 13'd0) && (q0_reg[1:0] == 2'b00));
    assign w0_next   = y0_reg + {2'b0, y0_reg[12:2]} - {6'b0, q0_reg} + {8'b0, q0_reg[6:2]};
    assign w1_next   = y1_reg + {2'b0, y1_reg[12:2]} - {6'b0, q1_reg} + {8'b0, q1_reg[6:2]};
    assign dn2_next  = dor_pkg::days_before(mo1_reg) + {4'b0, da1_reg}
                     + {8'b0, (leap_next && (mo1_reg > dor_pkg::MONTH_FEB))};

    always_ff @(posedge aclk) begin
        if (adv.st2) begin
            leap_reg <= leap_next;
            w0_reg   <= w0_next;
            w1_reg   <= w1_next;
            dn2_reg  <= dn2_next;
            hr2_reg  <= hr1_reg;
            mi2_reg  <= mi1_reg;
            se2_reg  <= se1_reg;
        end
    end

    // stage 3: seconds of the year, then carried to line up with the rule times
    logic [dor_pkg::SEC_W-1:0] now3_next, now3_reg, now4_reg, now5_reg, now6_reg;

    assign now3_next = {16'b0, dn2_reg} * 25'(dor_pkg::SEC_PER_DAY)
                     + {20'b0, hr2_reg} * 25'(dor_pkg::SEC_PER_HOUR)
                     + {19'b0, mi2_reg} * 25'(dor_pkg::SEC_PER_MIN)
                     + {19'b0, se2_reg};

    always_ff @(posedge aclk) begin
        if (adv.st3) begin
            now3_reg <= now3_next;
        end
        if (adv.st4) begin
            now4_reg <= now3_reg;
        end
        if (adv.st5) begin
            now5_reg <= now4_reg;
        end
        if (adv.st6) begin
            now6_reg <= now5_reg;
        end
    end

    assign wsum_cur  = w0_reg;
    assign wsum_prev = w1_reg;
    assign leap      = leap_reg;
    assign now_sec   = now6_reg;

endmodule

[hw/rtl/dor_rule_path.sv]
module dor_rule_path (
    input  logic                          aclk,
    input  dor_pkg::adv_t                 adv,
    input  logic [dor_pkg::RULE_W-1:0]    rule,
    input  logic [dor_pkg::WSUM_W-1:0]    wsum_cur,
    input  logic [dor_pkg::WSUM_W-1:0]    wsum_prev,
    input  logic                          leap,
    output logic [dor_pkg::SEC_W-1:0]     rule_sec
);

    logic [3:0] month;
    logic [3:0] wday;
    logic [2:0] occ;
    logic [4:0] hour;

    // the user must keep the rule static while items are in flight; the block does not enforce it
    assign month = dor_pkg::clamp_month(rule[14:11]);
    assign wday  = (rule[10:8] == 3'd0) ? 4'd7 : {1'b0, rule[10:8]};
    assign occ   = (rule[7:5] == 3'd0) ? 3'd1 : rule[7:5];
    assign hour  = rule[4:0];

    // stage 3: weekday sum of day one of the rule month
    logic [dor_pkg::WSUM_W-1:0] ws;
    logic [dor_pkg::WSUM_W-1:0] x_next, x_reg;
    logic                       leap3_reg, leap4_reg;

    assign ws     = (month > dor_pkg::MONTH_FEB) ? wsum_cur : wsum_prev;
    assign x_next = ws + {7'b0, dor_pkg::month_term(month)};

    always_ff @(posedge aclk) begin
        if (adv.st3) begin
            x_reg     <= x_next;
            leap3_reg <= leap;
        end
    end

    // stage 4: weekday of day one, 0 is sunday
    logic [2:0] wd_next, wd_reg;

    assign wd_next = dor_pkg::mod7(x_reg);

    always_ff @(posedge aclk) begin
        if (adv.st4) begin
            wd_reg    <= wd_next;
            leap4_reg <= leap3_reg;
        end
    end

    // stage 5: day of the nth weekday, pulled back into the month, and its day number
    logic [3:0] first;
    logic [3:0] ahead;
    logic [4:0] dom;
    logic [5:0] day_a, day_b, day_c, day_d;
    logic [dor_pkg::DAYN_W-1:0] dn_next, dn_reg;

    assign first = {1'b0, wd_reg} + 4'd1;
    assign ahead = (wday >= first) ? (wday - first) : (wday + 4'd7 - first);
    assign dom   = dor_pkg::days_in_month(month)
                 + {4'b0, (leap4_reg && (month == dor_pkg::MONTH_FEB))};
    assign day_a = 6'd1 + {2'b0, ahead} + {3'b0, (occ - 3'd1)} * 6'd7;
    assign day_b = (day_a > {1'b0, dom}) ? (day_a - 6'd7) : day_a;
    assign day_c = (day_b > {1'b0, dom}) ? (day_b - 6'd7) : day_b;
    assign day_d = (day_c > {1'b0, dom}) ? (day_c - 6'd7) : day_c;
    assign dn_next = dor_pkg::days_before(month) + {3'b0, day_d}
                   + {8'b0, (leap4_reg && (month > dor_pkg::MONTH_FEB))};

    always_ff @(posedge aclk) begin
        if (adv.st5) begin
            dn_reg <= dn_next;
        end
    end

    // stage 6: seconds of the year
    logic [dor_pkg::SEC_W-1:0] sec_next, sec_reg;

    assign sec_next = {16'b0, dn_reg} * 25'(dor_pkg::SEC_PER_DAY)
                    + {20'b0, hour} * 25'(dor_pkg::SEC_PER_HOUR);

    always_ff @(posedge aclk) begin
        if (adv.st6) begin
            sec_reg <= sec_next;
        end
    end

    assign rule_sec = sec_reg;

endmodule

[verif/tb_dst_offset_from_rules.sv]
module tb_dst_offset_from_rules;

    localparam int YEAR_W = dor_pkg::YEAR_W;
    localparam int RULE_W = dor_pkg::RULE_W;
    localparam int OFFS_W = dor_pkg::OFFS_W;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PIPE_LATENCY = 7;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
    } stamp_t;

    typedef struct packed {
        logic [OFFS_W-1:0] hours;
        logic              in_dst;
    } dst_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [1:0]           cfg_index;
    logic [RULE_W-1:0]    cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [YEAR_W-1:0]    s_cal_year;
    logic [3:0]           s_cal_month;
    logic [4:0]           s_cal_day;
    logic [4:0]           s_cal_hour;
    logic [5:0]           s_cal_minute;
    logic [5:0]           s_cal_second;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [OFFS_W-1:0]    m_dst_hours;
    logic                 m_in_dst;

    // rule registers as the block should hold them
    logic [RULE_W-1:0]    rule_start;
    logic [RULE_W-1:0]    rule_end;
    logic [OFFS_W-1:0]    hours_cfg;

    int unsigned month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int unsigned cum_days  [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    dst_result_t dst_due [$];
    dst_result_t want;

    bit src_stall_en;
    bit sink_stall_en;
    int sink_hold;
    int fail_cnt;
    int stamps_sent;
    int beats_seen;
    int settings_cnt;
    int cycle_cnt;

    dst_offset_from_rules i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cal_year   (s_cal_year),
        .s_cal_month  (s_cal_month),
        .s_cal_day    (s_cal_day),
        .s_cal_hour   (s_cal_hour),
        .s_cal_minute (s_cal_minute),
        .s_cal_second (s_cal_second),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_dst_hours  (m_dst_hours),
        .m_in_dst     (m_in_dst)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------- calendar predictor ----------------

    function automatic int unsigned fold_month(input int unsigned m);
        if (m < 1) begin
            return 1;
        end
        if (m > 12) begin
            return 12;
        end
        return m;
    endfunction

    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // 1 = sunday .. 7 = saturday; jan and feb count as months 13 and 14
    function automatic int unsigned day_of_week(input int unsigned yr, input int unsigned mo,
                                                input int unsigned dy);
        int unsigned m;
        int unsigned y;
        m = mo;
        y = yr + 400;
        if (m < 3) begin
            m = m + 12;
            y = y - 1;
        end
        return (dy + 2 * m + (6 * (m + 1)) / 10 + y + y / 4 - y / 100 + y / 400 + 1) % 7 + 1;
    endfunction

    function automatic longint unsigned year_seconds(input int unsigned yr, input int unsigned mo,
                                                     input int unsigned dy, input int unsigned hh,
                                                     input int unsigned mi, input int unsigned ss);
        longint unsigned dn;
        dn = cum_days[mo - 1] + dy;
        if (mo > 2 && is_leap_year(yr)) begin
            dn++;
        end
        return dn * 86400 + longint'(hh) * 3600 + longint'(mi) * 60 + ss;
    endfunction

    function automatic int unsigned rule_day(input int unsigned yr, input logic [RULE_W-1:0] r);
        int unsigned mo;
        int unsigned wd;
        int unsigned oc;
        int unsigned dim;
        int unsigned first_wd;
        int unsigned ahead;
        int unsigned dd;
        mo = fold_month(r[14:11]);
        wd = r[10:8];
        oc = r[7:5];
        if (wd == 0) begin
            wd = 7;
        end
        if (oc == 0) begin
            oc = 1;
        end
        dim = month_len[mo - 1];
        if (mo == 2 && is_leap_year(yr)) begin
            dim++;
        end
        first_wd = day_of_week(yr, mo, 1);
        ahead = (wd >= first_wd) ? wd - first_wd : wd + 7 - first_wd;
        dd = 1 + ahead + (oc - 1) * 7;
        // occurrence past the month pulls back to the last one
        while (dd > dim) begin
            dd = dd - 7;
        end
        return dd;
    endfunction

    function automatic longint unsigned rule_instant(input int unsigned yr,
                                                     input logic [RULE_W-1:0] r);
        return year_seconds(yr, fold_month(r[14:11]), rule_day(yr, r), r[4:0], 0, 0);
    endfunction

    function automatic dst_result_t predict_offset(input stamp_t st);
        longint unsigned now_s;
        longint unsigned on_s;
        longint unsigned off_s;
        bit in_window;
        dst_result_t r;
        now_s = year_seconds(st.year, fold_month(st.month), st.day, st.hour, st.minute,
                             st.second);
        on_s  = rule_instant(st.year, rule_start);
        off_s = rule_instant(st.year, rule_end);
        if (on_s < off_s) begin
            in_window = (now_s >= on_s) && (now_s < off_s);
        end else begin
            // southern window wraps the year end; equal instants mean always inside
            in_window = (now_s >= on_s) || (now_s < off_s);
        end
        r.hours  = in_window ? hours_cfg : '0;
        r.in_dst = in_window;
        return r;
    endfunction

    function automatic logic [RULE_W-1:0] pack_rule(input int unsigned mo, input int unsigned wd,
                                                   input int unsigned oc, input int unsigned hr);
        return {mo[3:0], wd[2:0], oc[2:0], hr[4:0]};
    endfunction

    function automatic logic [RULE_W-1:0] random_rule();
        if ($urandom_range(0, 4) == 0) begin
            return RULE_W'($urandom_range(0, 32767));
        end
        return pack_rule($urandom_range(1, 12), $urandom_range(1, 7), $urandom_range(1, 5),
                         $urandom_range(0, 23));
    endfunction

    // half are stamps close to a switch instant, then plain dates, then raw bits
    function automatic stamp_t random_stamp();
        stamp_t st;
        logic [RULE_W-1:0] r;
        int unsigned d;
        int unsigned h;
        int unsigned kind;
        int unsigned mo;
        kind = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) begin
            st.year = YEAR_W'($urandom_range(0, 4095));
        end else begin
            st.year = YEAR_W'($urandom_range(1900, 2100));
        end
        if (kind < 5) begin
            r = $urandom_range(0, 1) ? rule_start : rule_end;
            st.month = r[14:11];
            d = rule_day(st.year, r);
            h = r[4:0];
            st.minute = '0;
            st.second = '0;
            case ($urandom_range(0, 3))
                0: begin
                end
                1: begin
                    st.minute = 6'd59;
                    st.second = 6'd59;
                    if (h > 0) begin
                        h = h - 1;
                    end else begin
                        d = d - 1;
                        h = 23;
                    end
                end
                2: begin
                    st.minute = 6'($urandom_range(0, 59));
                    st.second = 6'($urandom_range(0, 59));
                end
                default: begin
                    d = d + $urandom_range(0, 2) - 1;
                    h = $urandom_range(0, 23);
                end
            endcase
            st.day  = 5'(d);
            st.hour = 5'(h);
        end else if (kind < 9) begin
            mo = $urandom_range(1, 12);
            st.month  = 4'(mo);
            st.day    = 5'($urandom_range(1, month_len[mo - 1]));
            st.hour   = 5'($urandom_range(0, 23));
            st.minute = 6'($urandom_range(0, 59));
            st.second = 6'($urandom_range(0, 59));
        end else begin
            st.month  = 4'($urandom_range(0, 15));
            st.day    = 5'($urandom_range(0, 31));
            st.hour   = 5'($urandom_range(0, 31));
            st.minute = 6'($urandom_range(0, 63));
            st.second = 6'($urandom_range(0, 63));
        end
        return st;
    endfunction

    // ---------------- driving ----------------

    task automatic send_stamp(input stamp_t st);
        if (src_stall_en && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cal_year   <= st.year;
        s_cal_month  <= st.month;
        s_cal_day    <= st.day;
        s_cal_hour   <= st.hour;
        s_cal_minute <= st.minute;
        s_cal_second <= st.second;
        do @(posedge aclk); while (!s_ready);
        dst_due.push_back(predict_offset(st));
        stamps_sent++;
    endtask

    task automatic send_stamp_fields(input int unsigned yr, input int unsigned mo,
                                     input int unsigned dy, input int unsigned hh,
                                     input int unsigned mi, input int unsigned ss);
        stamp_t st;
        st.year   = YEAR_W'(yr);
        st.month  = 4'(mo);
        st.day    = 5'(dy);
        st.hour   = 5'(hh);
        st.minute = 6'(mi);
        st.second = 6'(ss);
        send_stamp(st);
    endtask

    // the switch instant itself and the second just before it
    task automatic send_switch_pair(input int unsigned yr, input logic [RULE_W-1:0] r);
        int unsigned d;
        d = rule_day(yr, r);
        send_stamp_fields(yr, r[14:11], d, r[4:0], 0, 0);
        if (r[4:0] != 0) begin
            send_stamp_fields(yr, r[14:11], d, r[4:0] - 1, 59, 59);
        end else begin
            send_stamp_fields(yr, r[14:11], d - 1, 23, 59, 59);
        end
    endtask

    task automatic send_random_stamps(input int n);
        repeat (n) send_stamp(random_stamp());
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (dst_due.size() != 0) @(posedge aclk);
    endtask

    task automatic apply_rules(input logic [RULE_W-1:0] st_rule, input logic [RULE_W-1:0] en_rule,
                               input logic [OFFS_W-1:0] offs);
        cfg_we    <= 1'b1;
        cfg_index <= dor_pkg::CFG_START;
        cfg_wdata <= st_rule;
        @(posedge aclk);
        rule_start = st_rule;
        cfg_index <= dor_pkg::CFG_END;
        cfg_wdata <= en_rule;
        @(posedge aclk);
        rule_end = en_rule;
        cfg_index <= dor_pkg::CFG_OFFSET;
        cfg_wdata <= RULE_W'(offs);
        @(posedge aclk);
        hours_cfg = offs;
        cfg_we <= 1'b0;
        settings_cnt++;
    endtask

    // ---------------- result side ----------------

    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold = sink_hold - 1;
        end else if (sink_stall_en && $urandom_range(0, 7) == 0) begin
            sink_hold = $urandom_range(1, 6);
        end
        m_ready <= (sink_hold == 0);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (dst_due.size() == 0) begin
                $error("result beat with no timestamp outstanding");
                fail_cnt++;
            end else begin
                want = dst_due.pop_front();
                if (m_dst_hours !== want.hours) begin
                    $error("dst_hours: expected %0d, got %0d", want.hours, m_dst_hours);
                    fail_cnt++;
                end
                if (m_in_dst !== want.in_dst) begin
                    $error("in_dst: expected %0d, got %0d", want.in_dst, m_in_dst);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     dst_due.size());
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- tests ----------------

    task automatic test_default_window();
        send_switch_pair(2024, rule_start);
        send_switch_pair(2024, rule_end);
        send_switch_pair(1900, rule_start);
        send_switch_pair(1900, rule_end);
        drain_results();
    endtask

    task automatic test_field_extremes();
        send_stamp_fields(0, 0, 0, 0, 0, 0);
        send_stamp_fields(4095, 15, 31, 31, 63, 63);
        send_stamp_fields(0, 3, 10, 2, 0, 0);
        send_stamp_fields(1, 1, 1, 0, 0, 0);
        send_stamp_fields(2000, 2, 29, 12, 0, 0);
        send_stamp_fields(1900, 3, 1, 0, 0, 0);
        send_stamp_fields(2024, 12, 31, 23, 59, 59);
        send_stamp_fields(2023, 13, 31, 23, 59, 59);
        send_stamp_fields(2023, 11, 0, 31, 63, 63);
        drain_results();
    endtask

    // weekday zero, occurrence zero and past the month, odd months, wrapped windows
    task automatic test_rule_corners();
        logic [RULE_W-1:0] st_list [6];
        logic [RULE_W-1:0] en_list [6];
        logic [OFFS_W-1:0] of_list [6];
        st_list = '{pack_rule(0, 0, 0, 0), pack_rule(6, 3, 2, 12), pack_rule(10, 1, 1, 2),
                    pack_rule(2, 2, 5, 0), RULE_W'(15'h7FFF), pack_rule(3, 1, 7, 23)};
        en_list = '{pack_rule(15, 7, 7, 31), pack_rule(6, 3, 2, 12), pack_rule(4, 1, 1, 3),
                    pack_rule(2, 6, 7, 23), RULE_W'(0), pack_rule(13, 0, 6, 1)};
        of_list = '{4'd15, 4'd9, 4'd15, 4'd7, 4'd0, 4'd3};
        for (int k = 0; k < 6; k++) begin
            apply_rules(st_list[k], en_list[k], of_list[k]);
            send_switch_pair(2024, rule_start);
            send_switch_pair(2023, rule_end);
            send_random_stamps(12);
            drain_results();
        end
    endtask

    task automatic test_random_rules();
        for (int p = 0; p < 12; p++) begin
            src_stall_en  = (p < 10) && (p % 4 == 0 || p % 4 == 1);
            sink_stall_en = (p < 10) && (p % 4 == 0 || p % 4 == 2);
            apply_rules(random_rule(), random_rule(), OFFS_W'($urandom_range(0, 15)));
            if (p == 5) begin
                send_random_stamps(75);
                // sender holds off until everything in flight is back
                drain_results();
                send_random_stamps(75);
            end else begin
                send_random_stamps(150);
            end
            drain_results();
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = dor_pkg::CFG_START;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_cal_year   = '0;
        s_cal_month  = '0;
        s_cal_day    = '0;
        s_cal_hour   = '0;
        s_cal_minute = '0;
        s_cal_second = '0;
        rule_start   = dor_pkg::START_RULE_RST;
        rule_end     = dor_pkg::END_RULE_RST;
        hours_cfg    = dor_pkg::OFFSET_RST;
        src_stall_en  = 1'b1;
        sink_stall_en = 1'b1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_window();
        test_field_extremes();
        test_rule_corners();
        test_random_rules();

        drain_results();
        repeat (PIPE_LATENCY + 3) @(posedge aclk);
        if (dst_due.size() != 0) begin
            $error("%0d results never arrived", dst_due.size());
            fail_cnt++;
        end
        $display("sent %0d timestamps under %0d rule settings, checked %0d result beats",
                 stamps_sent, settings_cnt + 1, beats_seen);
        $display("covered wrapped and equal windows, odd rule fields and raw field extremes");
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
